// File: design/rlps_pkg.sv
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types and constants of the LED strip pulse serializer.
// ----------------------------------------------------------------------------
package rlps_pkg;

    localparam int HIGH_W  = 10;
    localparam int LATCH_W = 16;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_ZERO_HIGH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_ONE_HIGH   = 2'd1;
    localparam logic [IDX_W-1:0] REG_BIT_PERIOD = 2'd2;
    localparam logic [IDX_W-1:0] REG_LATCH      = 2'd3;

    localparam logic [HIGH_W-1:0]  ZERO_HIGH_RST  = 10'd20;
    localparam logic [HIGH_W-1:0]  ONE_HIGH_RST   = 10'd40;
    localparam logic [HIGH_W-1:0]  BIT_PERIOD_RST = 10'd63;
    localparam logic [LATCH_W-1:0] LATCH_RST      = 16'd2500;

    localparam logic [HIGH_W-1:0]  MIN_PERIOD = 10'd2;
    localparam logic [HIGH_W-1:0]  MIN_HIGH   = 10'd1;
    localparam logic [LATCH_W-1:0] MIN_LATCH  = 16'd1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_LATCH = 2'd2
    } phase_t;

    typedef struct packed {
        logic [HIGH_W-1:0]  zero_high_ticks;
        logic [HIGH_W-1:0]  one_high_ticks;
        logic [HIGH_W-1:0]  bit_period_ticks;
        logic [LATCH_W-1:0] latch_ticks;
    } cfg_t;

    typedef struct packed {
        logic frame_done;
        logic overrun;
        logic ready_res;
        logic line_level;
    } res_t;

endpackage

// File: design/rlps_cfg.sv
// ----------------------------------------------------------------------------
// rlps_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rlps_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rlps_pkg::IDX_W-1:0]     cfg_index,
    input  logic [rlps_pkg::CFG_W-1:0]     cfg_data,
    output rlps_pkg::cfg_t                 cfg
);

    rlps_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high_ticks  <= rlps_pkg::ZERO_HIGH_RST;
            cfg_reg.one_high_ticks   <= rlps_pkg::ONE_HIGH_RST;
            cfg_reg.bit_period_ticks <= rlps_pkg::BIT_PERIOD_RST;
            cfg_reg.latch_ticks      <= rlps_pkg::LATCH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlps_pkg::REG_ZERO_HIGH:
                    cfg_reg.zero_high_ticks <= cfg_data[rlps_pkg::HIGH_W-1:0];
                rlps_pkg::REG_ONE_HIGH:
                    cfg_reg.one_high_ticks <= cfg_data[rlps_pkg::HIGH_W-1:0];
                rlps_pkg::REG_BIT_PERIOD:
                    cfg_reg.bit_period_ticks <= cfg_data[rlps_pkg::HIGH_W-1:0];
                rlps_pkg::REG_LATCH:
                    cfg_reg.latch_ticks <= cfg_data[rlps_pkg::LATCH_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/rlps_core.sv
// ----------------------------------------------------------------------------
// rlps_core
// Bit and latch timing state; advances one tick per accepted request.
// ----------------------------------------------------------------------------
module rlps_core #(
    parameter int COLOR_BYTES = 3
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           mode,
    input  logic [7:0]     red,
    input  logic [7:0]     green,
    input  logic [7:0]     blue,
    input  logic           last_pixel,
    input  rlps_pkg::cfg_t cfg,
    output rlps_pkg::res_t res
);

    localparam int TOTAL_BITS = 8 * COLOR_BYTES;
    localparam int BITS_W     = $clog2(TOTAL_BITS);
    localparam int TW         = rlps_pkg::TICK_W;
    localparam int HW         = rlps_pkg::HIGH_W;

    logic [TOTAL_BITS-1:0] shift_reg, shift_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    logic [TW-1:0]         tick_reg, tick_next;
    rlps_pkg::phase_t      phase_reg, phase_next;
    logic                  pend_reg, pend_next;

    logic                  idle;
    logic [HW-1:0]         period;
    logic [HW-1:0]         high;
    logic [TW-1:0]         tick_inc;
    logic [TW-1:0]         need;

    always_comb
    begin
        shift_next = shift_reg;
        bits_next  = bits_reg;
        tick_next  = tick_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        res        = '0;

        idle          = (phase_reg != rlps_pkg::PH_SEND) && (phase_reg != rlps_pkg::PH_LATCH);
        res.ready_res = idle;

        if (mode)
        begin
            if (idle)
            begin
                shift_next = TOTAL_BITS'({green, red, blue}) << (TOTAL_BITS - 24);
                bits_next  = BITS_W'(TOTAL_BITS - 1);
                tick_next  = '0;
                pend_next  = last_pixel;
                phase_next = rlps_pkg::PH_SEND;
            end
            else
            begin
                res.overrun = 1'b1;
            end
        end

        period = (cfg.bit_period_ticks < rlps_pkg::MIN_PERIOD) ? rlps_pkg::MIN_PERIOD
                                                                 : cfg.bit_period_ticks;
        high   = shift_next[TOTAL_BITS-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
        if (high < rlps_pkg::MIN_HIGH)
            high = rlps_pkg::MIN_HIGH;
        if (high > period - 1'b1)
            high = period - 1'b1;
        need     = (cfg.latch_ticks < rlps_pkg::MIN_LATCH) ? rlps_pkg::MIN_LATCH
                                                           : cfg.latch_ticks;
        tick_inc = tick_next + 1'b1;

        unique case (phase_next)
            rlps_pkg::PH_SEND:
            begin
                res.line_level = (tick_next < TW'(high));
                tick_next      = tick_inc;
                if (tick_inc >= TW'(period))
                begin
                    tick_next = '0;
                    if (bits_next == '0)
                    begin
                        phase_next = pend_next ? rlps_pkg::PH_LATCH : rlps_pkg::PH_IDLE;
                    end
                    else
                    begin
                        shift_next = shift_next << 1;
                        bits_next  = bits_next - 1'b1;
                    end
                end
            end
            rlps_pkg::PH_LATCH:
            begin
                tick_next = tick_inc;
                if (tick_inc >= need)
                begin
                    res.frame_done = 1'b1;
                    tick_next      = '0;
                    phase_next     = rlps_pkg::PH_IDLE;
                    pend_next      = 1'b0;
                end
            end
            default:
            begin
                tick_next = tick_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            bits_reg  <= '0;
            tick_reg  <= '0;
            phase_reg <= rlps_pkg::PH_IDLE;
            pend_reg  <= 1'b0;
        end
        else if (accept)
        begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            tick_reg  <= tick_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// File: design/rgb_led_pulse_serializer_top.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_serializer_top
// Self-clocked LED strip data line driver, one request per line tick.
// ----------------------------------------------------------------------------
// An accepted request's result is registered and shown on m_ in the next cycle.
// Throughput: one request per cycle unless m_ stalls; the timing state updates
// in a single pass and the result register refills in the cycle it is taken.
// Reset: rst_n clears the timing state and output valid at once and loads the
// timing registers with their default tick counts.
// ----------------------------------------------------------------------------
module rgb_led_pulse_serializer_top #(
    parameter int COLOR_BYTES = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // red, green, blue
    input  logic                       s_tuser,   // mode
    input  logic                       s_tlast,   // last_pixel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // line_level, ready_res, overrun, zero pad
    output logic                       m_tlast,   // frame_done
    input  logic                       cfg_we,
    input  logic [rlps_pkg::IDX_W-1:0] cfg_index,
    input  logic [rlps_pkg::CFG_W-1:0] cfg_data
);

    rlps_pkg::cfg_t cfg;
    rlps_pkg::res_t res;
    rlps_pkg::res_t res_reg;
    logic           out_valid_reg;
    logic           accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    rlps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlps_core #(
        .COLOR_BYTES (COLOR_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (s_tuser),
        .red        (s_tdata[7:0]),
        .green      (s_tdata[15:8]),
        .blue       (s_tdata[23:16]),
        .last_pixel (s_tlast),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg.overrun, res_reg.ready_res, res_reg.line_level};
    assign m_tlast  = res_reg.frame_done;

`ifndef NO_ASSERTIONS
    a_overrun_busy : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("overrun reported while idle");

    a_done_low : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[0] && !m_tdata[1])
        else $error("frame done with line high or idle");

    a_accept_result : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");
`endif

endmodule
